// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while the block is out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset cycles included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dtt_pkg.sv =====
// Types, constants and helpers shared by the tokenizer modules.
package dtt_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int MAX_TOKENS        = 3;
  localparam int QUEUE_DEPTH       = 4;
  localparam int CFG_ADDR_BITS     = 2;
  localparam int CFG_DATA_BITS     = 64;

  localparam logic [CFG_ADDR_BITS-1:0] CFG_DELIM_LOW  = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_DELIM_HIGH = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_KEEP       = 2'd2;

  localparam logic [63:0] DELIM_LOW_RST  = 64'hFC00_FFFF_FFFF_0000 & 64'd18158794597008932864;
  localparam logic [63:0] DELIM_HIGH_RST = 64'd7493989786252738561;

  localparam logic [1:0] KIND_WORD    = 2'd0;
  localparam logic [1:0] KIND_DELIM   = 2'd1;
  localparam logic [1:0] KIND_QUOTE   = 2'd2;
  localparam logic [1:0] KIND_LITERAL = 2'd3;

  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_DQ    = 8'h22;
  localparam logic [7:0] CHAR_SQ    = 8'h27;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  typedef struct packed {
    logic [15:0] col;
    logic [15:0] line;
    logic [15:0] end_ofs;
    logic [15:0] start_ofs;
    logic [1:0]  kind;
  } record_t;

  typedef struct packed {
    logic [1:0]                   cnt;
    record_t [MAX_TOKENS-1:0]     rec;
  } bundle_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic record_t make_rec(input logic [1:0] kind, input logic [15:0] s,
                                       input logic [15:0] e, input logic [15:0] ln,
                                       input logic [15:0] cl);
    make_rec.kind      = kind;
    make_rec.start_ofs = s;
    make_rec.end_ofs   = e;
    make_rec.line      = ln;
    make_rec.col       = cl;
  endfunction

endpackage

// ===== rtl/dtt_front.sv =====
// Front end: classifies each text byte and builds the bundle of tokens it closes.
module dtt_front #(
  parameter int POSITION_BITS = dtt_pkg::POSITION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,
  input  logic                               in_tlast,
  input  logic                               cfg_we,
  input  logic [dtt_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [dtt_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  input  logic                               q_full,
  output logic                               q_push,
  output dtt_pkg::bundle_t                   q_data
);
  import dtt_pkg::*;

  logic [63:0] delim_low_r, delim_high_r;
  logic        keep_r;

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [15:0] line_r, line_nxt, col_r, col_nxt;
  logic        word_open_r, word_open_nxt;
  logic [POSITION_BITS-1:0] ws_r, ws_nxt;
  logic [15:0] wline_r, wline_nxt, wcol_r, wcol_nxt;
  logic        quote_open_r, quote_open_nxt;
  logic        quote_dq_r, quote_dq_nxt;
  logic        slash_r, slash_nxt;
  logic        prev_lf_r, prev_lf_nxt, prev_cr_r, prev_cr_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        eot;
  logic        is_delim, is_space, is_quote, is_break;
  logic [15:0] pos16, pos_m1_16, ws16, ws_p1_16;
  logic [POSITION_BITS-1:0] ws_p1, pos_m1;
  logic [1:0]  n;
  bundle_t     bun;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign eot       = in_tlast;

  assign is_delim = !b[7] && (b[6] ? delim_high_r[b[5:0]] : delim_low_r[b[5:0]]);
  assign is_space = (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
  assign is_quote = (b == CHAR_SQ) || (b == CHAR_DQ);
  assign is_break = (b == CHAR_LF) || (b == CHAR_CR);

  // The offset arithmetic wraps at the position width before it is cut to 16 bits.
  assign ws_p1     = ws_r + 1'b1;
  assign pos_m1    = pos_r - 1'b1;
  assign pos16     = 16'(pos_r);
  assign pos_m1_16 = 16'(pos_m1);
  assign ws16      = 16'(ws_r);
  assign ws_p1_16  = 16'(ws_p1);

  always_comb begin
    logic consumed;
    consumed       = 1'b0;
    n              = 2'd0;
    bun            = '0;
    pos_nxt        = pos_r + 1'b1;
    line_nxt       = line_r;
    col_nxt        = col_r;
    word_open_nxt  = word_open_r;
    ws_nxt         = ws_r;
    wline_nxt      = wline_r;
    wcol_nxt       = wcol_r;
    quote_open_nxt = quote_open_r;
    quote_dq_nxt   = quote_dq_r;
    slash_nxt      = slash_r;
    prev_lf_nxt    = 1'b0;
    prev_cr_nxt    = 1'b0;

    if (quote_open_r) begin
      if (b == (quote_dq_r ? CHAR_DQ : CHAR_SQ)) begin
        if (keep_r) begin
          if (ws_p1 != pos_r) begin
            bun.rec[n] = make_rec(KIND_LITERAL, ws_p1_16, pos_m1_16, wline_r, sat_inc(wcol_r));
            n = n + 2'd1;
          end
          bun.rec[n] = make_rec(KIND_QUOTE, pos16, pos16, line_r, col_r);
          n = n + 2'd1;
        end else begin
          bun.rec[n] = make_rec(KIND_LITERAL, ws16, pos16, wline_r, wcol_r);
          n = n + 2'd1;
        end
        quote_open_nxt = 1'b0;
      end else if (eot) begin
        if (keep_r) begin
          bun.rec[n] = make_rec(KIND_LITERAL, ws_p1_16, pos16, wline_r, sat_inc(wcol_r));
        end else begin
          bun.rec[n] = make_rec(KIND_LITERAL, ws16, pos16, wline_r, wcol_r);
        end
        n = n + 2'd1;
        quote_open_nxt = 1'b0;
      end
    end else begin
      if (slash_r) begin
        slash_nxt = 1'b0;
        if (b == CHAR_SLASH && is_delim) begin
          bun.rec[n] = make_rec(KIND_DELIM, ws16, pos16, wline_r, wcol_r);
          consumed = 1'b1;
        end else begin
          bun.rec[n] = make_rec(KIND_DELIM, ws16, ws16, wline_r, wcol_r);
        end
        n = n + 2'd1;
      end
      if (!consumed) begin
        if (is_delim || is_quote || is_space) begin
          // Any of these bytes ends an open word.
          if (word_open_r) begin
            bun.rec[n] = make_rec(KIND_WORD, ws16, pos_m1_16, wline_r, wcol_r);
            n = n + 2'd1;
            word_open_nxt = 1'b0;
          end
        end
        if (is_delim) begin
          if (keep_r) begin
            if (b == CHAR_SLASH && !eot) begin
              // Hold the slash one byte to see whether a second one follows.
              slash_nxt = 1'b1;
              ws_nxt    = pos_r;
              wline_nxt = line_r;
              wcol_nxt  = col_r;
            end else begin
              bun.rec[n] = make_rec(KIND_DELIM, pos16, pos16, line_r, col_r);
              n = n + 2'd1;
            end
          end
        end else if (is_quote) begin
          if (keep_r) begin
            bun.rec[n] = make_rec(KIND_QUOTE, pos16, pos16, line_r, col_r);
            n = n + 2'd1;
          end
          if (eot) begin
            if (!keep_r) begin
              bun.rec[n] = make_rec(KIND_LITERAL, pos16, pos16, line_r, col_r);
              n = n + 2'd1;
            end
          end else begin
            quote_open_nxt = 1'b1;
            quote_dq_nxt   = (b == CHAR_DQ);
            ws_nxt         = pos_r;
            wline_nxt      = line_r;
            wcol_nxt       = col_r;
          end
        end else if (!is_space) begin
          if (!word_open_r) begin
            word_open_nxt = 1'b1;
            ws_nxt        = pos_r;
            wline_nxt     = line_r;
            wcol_nxt      = col_r;
          end
          if (eot) begin
            bun.rec[n] = make_rec(KIND_WORD, 16'(ws_nxt), pos16, wline_nxt, wcol_nxt);
            n = n + 2'd1;
          end
        end
      end
    end

    // CRLF and LFCR pairs count as a single line break.
    if (is_break) begin
      if ((b == CHAR_LF && prev_cr_r) || (b == CHAR_CR && prev_lf_r)) begin
        prev_lf_nxt = 1'b0;
        prev_cr_nxt = 1'b0;
      end else begin
        line_nxt    = sat_inc(line_r);
        prev_lf_nxt = (b == CHAR_LF);
        prev_cr_nxt = (b == CHAR_CR);
      end
      col_nxt = 16'd1;
    end else begin
      col_nxt = sat_inc(col_r);
    end

    if (eot) begin
      pos_nxt        = '0;
      line_nxt       = 16'd1;
      col_nxt        = 16'd1;
      word_open_nxt  = 1'b0;
      ws_nxt         = '0;
      wline_nxt      = 16'd1;
      wcol_nxt       = 16'd1;
      quote_open_nxt = 1'b0;
      quote_dq_nxt   = 1'b0;
      slash_nxt      = 1'b0;
      prev_lf_nxt    = 1'b0;
      prev_cr_nxt    = 1'b0;
    end
    bun.cnt = n;
  end

  assign q_push = accept && (n != 2'd0);
  assign q_data = bun;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_low_r  <= DELIM_LOW_RST;
      delim_high_r <= DELIM_HIGH_RST;
      keep_r       <= 1'b0;
      pos_r        <= '0;
      line_r       <= 16'd1;
      col_r        <= 16'd1;
      word_open_r  <= 1'b0;
      ws_r         <= '0;
      wline_r      <= 16'd1;
      wcol_r       <= 16'd1;
      quote_open_r <= 1'b0;
      quote_dq_r   <= 1'b0;
      slash_r      <= 1'b0;
      prev_lf_r    <= 1'b0;
      prev_cr_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_DELIM_LOW:  delim_low_r  <= cfg_wdata;
          CFG_DELIM_HIGH: delim_high_r <= cfg_wdata;
          CFG_KEEP:       keep_r       <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (accept) begin
        pos_r        <= pos_nxt;
        line_r       <= line_nxt;
        col_r        <= col_nxt;
        word_open_r  <= word_open_nxt;
        ws_r         <= ws_nxt;
        wline_r      <= wline_nxt;
        wcol_r       <= wcol_nxt;
        quote_open_r <= quote_open_nxt;
        quote_dq_r   <= quote_dq_nxt;
        slash_r      <= slash_nxt;
        prev_lf_r    <= prev_lf_nxt;
        prev_cr_r    <= prev_cr_nxt;
      end
    end
  end

endmodule

// ===== rtl/dtt_queue.sv =====
// Short register queue of token bundles between the front and back ends.
module dtt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dtt_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output dtt_pkg::bundle_t pop_data
);
  import dtt_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  bundle_t               mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic                  do_push, do_pop;

  assign full     = (count_r == CNT_BITS'(QUEUE_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = mem_r[rptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/dtt_back.sv =====
// Back end: holds one bundle and hands its tokens out one transaction at a time.
module dtt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  dtt_pkg::bundle_t q_data,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [63:0]      out_tdata,
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);
  import dtt_pkg::*;

  bundle_t     cur_r;
  logic        cur_valid_r, cur_valid_nxt;
  logic [1:0]  idx_r, idx_nxt;
  record_t     rec;
  logic        last, load;

  assign rec        = cur_r.rec[idx_r];
  assign last       = (idx_r == cur_r.cnt - 2'd1);
  assign out_tvalid = cur_valid_r;
  assign out_tdata  = {rec.col, rec.line, rec.end_ofs, rec.start_ofs};
  assign out_tuser  = rec.kind;
  assign out_tlast  = last;

  // A new bundle is taken as soon as the last token of the current one leaves.
  assign load  = !cur_valid_r || (out_tready && last);
  assign q_pop = load && q_valid;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      cur_valid_nxt = q_valid;
      idx_nxt       = 2'd0;
    end else if (out_tready) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

endmodule

// ===== rtl/delimiter_text_tokenizer.sv =====
// A token is registered in the queue and then in the output stage before it leaves.
// Throughput: one byte per cycle while the queue is not full and each byte closes at
// most one token; a byte that closes up to two tokens hands them out one at a time,
// and a four-bundle queue between classifier and output stage absorbs such bursts.
// Reset: synchronous, active low; clears text state and the queue, and loads the
// default delimiter set with keep mode off.
module delimiter_text_tokenizer #(
  parameter int POSITION_BITS = dtt_pkg::POSITION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // text_byte
  input  logic                               in_tlast,   // end_of_text
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // start_offset, end_offset, line_number, column_number
  output logic [63:0]                        out_tdata,
  output logic [1:0]                         out_tuser,  // token_kind
  output logic                               out_tlast,  // last_of_run
  input  logic                               cfg_we,
  input  logic [dtt_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [dtt_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import dtt_pkg::*;

  logic    q_push, q_full, q_pop, q_valid;
  bundle_t q_wdata, q_rdata;

  dtt_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  dtt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_rdata)
  );

  dtt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/dtt_checker.sv =====
// Port-level checks for the tokenizer, bound to its top level.
`include "assert_macros.svh"

module dtt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import dtt_pkg::*;

  `ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_tvalid, "output valid after reset")
  `ASSERT_CLK(a_stall_holds, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled token changed")
  `ASSERT_CLK(a_quote_one_byte, out_tvalid && out_tuser == KIND_QUOTE |-> out_tdata[15:0] == out_tdata[31:16], "quote mark spans more than one byte")
  // The queue fills only while the output stage holds a token.
  `ASSERT_CLK(a_full_implies_out, !in_tready |-> out_tvalid, "input stalled with no token offered")

endmodule

bind delimiter_text_tokenizer dtt_checker u_checker (.*);
